// ===== rtl/pirs_pkg.sv =====
// Shared widths, register indexes and arithmetic helpers for the resampler.
package pirs_pkg;

    // Sample and position formats
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int STEP_BITS   = FRAC_BITS + 5;
    localparam int POS_BITS    = STEP_BITS + 1;
    localparam int RESULT_CAP  = 16;
    localparam int COUNT_BITS  = $clog2(RESULT_CAP + 1);

    // Datapath widths: accumulator and shared multiplier product
    localparam int ACC_BITS  = SAMPLE_BITS + 8;
    localparam int PROD_BITS = ACC_BITS + FRAC_BITS + 1;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = STEP_BITS;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_INTERP_MODE = t_cfg_idx'(0);
    localparam t_cfg_idx REG_PHASE_STEP  = t_cfg_idx'(1);

    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(65536);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [ACC_BITS-1:0]    t_acc;
    typedef logic signed [PROD_BITS-1:0]   t_prod;
    typedef logic [POS_BITS-1:0]           t_pos;

    localparam t_pos  POS_ONE   = t_pos'(1) << FRAC_BITS;
    localparam t_prod PROD_HALF = t_prod'(1) << (FRAC_BITS - 1);
    localparam t_acc  SAT_MAX   = (t_acc'(1) << (SAMPLE_BITS - 1)) - t_acc'(1);
    localparam t_acc  SAT_MIN   = -(t_acc'(1) << (SAMPLE_BITS - 1));

    // Sign-extend a sample to accumulator width
    function automatic t_acc widen(input t_sample s);
        widen = {{(ACC_BITS - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    endfunction

endpackage

// ===== rtl/polynomial_interpolating_resampler_unit.sv =====
// Fractional resampler: linear or Catmull-Rom cubic interpolation over one shared multiplier.
// Each result runs through S_CHECK, then S_MUL and S_ADD (once for linear, three times for
// cubic), then S_SAT and S_OUT; an accepted input word first passes S_COEF. One input
// yields up to 16 results and holds the input side (o_stall) until the sequencer is back
// in S_IDLE; output stalls extend this. The single multiplier runs the Horner steps one
// after another. Synchronous active-low reset clears history, position and control, and
// loads interp_mode = 1 and phase_step = 1.0.
module polynomial_interpolating_resampler_unit
    import pirs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    // input samples
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    // output samples
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                     o_last_of_run
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_COEF  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_SAT   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_mode;
    logic [STEP_BITS-1:0]    r_step;
    t_sample                 r_hist [4];
    t_pos                    r_pos, n_pos;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic                    r_cubic;
    t_acc                    r_coef [4];
    logic [1:0]              r_k, n_k;
    t_acc                    r_t, n_t;
    t_prod                   r_prod;
    t_sample                 r_out;
    logic                    r_last;

    logic                    in_take;
    logic                    out_take;
    t_prod                   prod_rnd;
    t_acc                    t_round;
    t_acc                    y_full;
    t_acc                    h0, h1, h2, h3;
    t_pos                    pos_next;

    assign in_take  = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_sample_out  = r_out;
    assign o_last_of_run = r_last;

    assign h0 = widen(r_hist[0]);
    assign h1 = widen(r_hist[1]);
    assign h2 = widen(r_hist[2]);
    assign h3 = widen(r_hist[3]);

    // Round the product back to accumulator scale (floor of p + half over 2^FRAC_BITS)
    assign prod_rnd = r_prod + PROD_HALF;
    assign t_round  = prod_rnd[FRAC_BITS +: ACC_BITS];

    // Cubic coefficients are kept doubled; halve with rounding at the end
    assign y_full   = r_cubic ? ((r_t + t_acc'(1)) >>> 1) : r_t;
    assign pos_next = r_pos + t_pos'(r_step);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_step <= STEP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_INTERP_MODE: r_mode <= i_cfg_wdata[0];
                REG_PHASE_STEP:  r_step <= i_cfg_wdata[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sample history: shift in on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_hist[i] <= '0;
            end
        end else if (in_take) begin
            r_hist[0] <= r_hist[1];
            r_hist[1] <= r_hist[2];
            r_hist[2] <= r_hist[3];
            r_hist[3] <= i_sample_in;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_count = r_count;
        n_k     = r_k;
        n_t     = r_t;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_count = '0;
                    n_state = S_COEF;
                end
            end
            S_COEF: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_pos < POS_ONE && r_count < COUNT_BITS'(RESULT_CAP)) begin
                    n_t     = r_coef[0];
                    n_k     = r_cubic ? 2'd1 : 2'd3;
                    n_state = S_MUL;
                end else begin
                    n_pos   = (r_pos >= POS_ONE) ? (r_pos - POS_ONE) : '0;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_t = t_round + r_coef[r_k];
                if (r_k == 2'd3) begin
                    n_state = S_SAT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_SAT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_take) begin
                    n_pos   = pos_next;
                    n_count = r_count + COUNT_BITS'(1);
                    n_state = S_CHECK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_count <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_k     <= n_k;
        end
    end

    // Datapath: coefficients, shared multiplier, accumulator, saturated output
    always_ff @(posedge i_clk) begin
        r_t <= n_t;
        if (r_state == S_COEF) begin
            r_cubic <= r_mode;
            if (r_mode) begin
                r_coef[0] <= (h3 - h0) + (h1 - h2) + ((h1 - h2) <<< 1);
                r_coef[1] <= (h0 <<< 1) - (h1 <<< 2) - h1 + (h2 <<< 2) - h3;
                r_coef[2] <= h2 - h0;
                r_coef[3] <= h1 <<< 1;
            end else begin
                r_coef[0] <= h2 - h1;
                r_coef[1] <= '0;
                r_coef[2] <= '0;
                r_coef[3] <= h1;
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= t_prod'(r_t) * t_prod'($signed({1'b0, r_pos[FRAC_BITS-1:0]}));
        end
        if (r_state == S_SAT) begin
            if (y_full > SAT_MAX) begin
                r_out <= SAT_MAX[SAMPLE_BITS-1:0];
            end else if (y_full < SAT_MIN) begin
                r_out <= SAT_MIN[SAMPLE_BITS-1:0];
            end else begin
                r_out <= y_full[SAMPLE_BITS-1:0];
            end
            r_last <= (pos_next >= POS_ONE) || (r_count == COUNT_BITS'(RESULT_CAP - 1));
        end
    end

endmodule

// ===== rtl/pirs_checker.sv =====
// Port-level checker for the resampler, bound to the top level.
module pirs_checker
    import pirs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     o_stall,
    input  logic                     o_valid,
    input  logic                     i_stall,
    input  logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input  logic                     o_last_of_run
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample_out) && $stable(o_last_of_run))
        else $error("output word changed while stalled");

    // Input side stays closed while a result is shown
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while output word pending");

    // No result, and the input side closed, in the cycle right after a word is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid && o_stall)
        else $error("result or ready too soon after input word");

    // Reset leaves the output empty and the input open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

endmodule

bind polynomial_interpolating_resampler_unit pirs_checker u_pirs_checker (.*);
